>>> hw/rtl/fifo_queue_with_promote_unit_defines.svh
// ----------------------------------------------------------------------------
// fifo_queue_with_promote_unit_defines: assertion macros
// Concurrent assertion wrappers that fall away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_PROMOTE_UNIT_DEFINES_SVH
`define FIFO_QUEUE_WITH_PROMOTE_UNIT_DEFINES_SVH

`ifndef SYNTH
// Property that must hold at every edge outside reset
`define FQP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("fqp assertion failed");
// Condition in one cycle implies a consequence in the next
`define FQP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fqp next-cycle assertion failed");
`else
`define FQP_ASSERT(lbl, clk, rstn, prop)
`define FQP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> hw/rtl/fqp_pkg.sv
// ----------------------------------------------------------------------------
// fqp_pkg
// Shared constants, codes and cell control types of the promote queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fqp_pkg;

  localparam int DEPTH = 16;
  localparam int DataW = 32;
  localparam int CntW  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ENQ     = 2'd0,
    OP_DEQ     = 2'd1,
    OP_PEEK    = 2'd2,
    OP_PROMOTE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_ENQ  = 2'd1,
    CELL_DEQ  = 2'd2,
    CELL_PRO  = 2'd3
  } cell_op_t;

  // Broadcast control for every cell of the chain
  typedef struct packed {
    cell_op_t              op;
    logic [DataW-1:0]      value;
    logic [CntW-1:0]       count;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/fqp_cell.sv
// ----------------------------------------------------------------------------
// fqp_cell
// One queue slot: holds a word, compares it against the search word and
// takes a word from its left or right neighbor when the queue shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fqp_cell (
  input  wire logic                        clk,
  input  wire fqp_pkg::cell_ctl_t          ctl,
  input  wire logic                        found,
  input  wire logic [fqp_pkg::CntW-1:0]    idx,
  input  wire logic [fqp_pkg::DataW-1:0]   left_data,
  input  wire logic [fqp_pkg::DataW-1:0]   right_data,
  input  wire logic                        hit_in,
  output logic                             hit_out,
  output logic [fqp_pkg::DataW-1:0]        data_q
);

  logic [fqp_pkg::DataW-1:0] data_r;
  logic [fqp_pkg::DataW-1:0] data_nxt;
  logic                      occ;
  logic                      hit;

  // Match only occupied slots; pass the earliest-match flag down the chain
  assign occ     = idx < ctl.count;
  assign hit     = occ && (data_r == ctl.value);
  assign hit_out = hit_in | hit;
  assign data_q  = data_r;

  // Pick next word: write at tail, shift toward head, or shift away for promote
  always_comb begin
    data_nxt = data_r;
    unique case (ctl.op)
      fqp_pkg::CELL_HOLD: data_nxt = data_r;
      fqp_pkg::CELL_ENQ: begin
        if (idx == ctl.count) data_nxt = ctl.value;
      end
      fqp_pkg::CELL_DEQ: data_nxt = right_data;
      fqp_pkg::CELL_PRO: begin
        if (found && !hit_in) data_nxt = left_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  // Hold the slot word
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

>>> hw/rtl/fifo_queue_with_promote_unit.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_promote_unit
// Bounded FIFO of 32-bit words with enqueue, dequeue, peek and promote,
// built as a row of slot cells that shift in either direction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries in_opcode and in_value. A word is
//   accepted at an edge with in_valid high and in_stall low.
//   Result channel out_valid/out_stall carries out_data, out_status,
//   out_empty_res and out_count, one result word per input word.
//   Result: registered and presented in the cycle after acceptance.
//   Throughput: one word per cycle while no result waits under out_stall;
//   the promote search runs the match flag through all 16 slot cells
//   combinationally, which sets the cycle length.
//   Stall: while a result waits under out_stall, in_stall is high and the
//   queue holds; once the result is taken a new word enters the same cycle.
//   Reset: rst_n low clears the entry count and the result valid; slot
//   contents are left as they are and are never read before being written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fifo_queue_with_promote_unit_defines.svh"

module fifo_queue_with_promote_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_opcode,
  input  wire logic [31:0]                 in_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [31:0]                      out_data,
  output logic [1:0]                       out_status,
  output logic                             out_empty_res,
  output logic [4:0]                       out_count
);

  localparam int DEPTH = fqp_pkg::DEPTH;
  localparam int DataW = fqp_pkg::DataW;
  localparam int CntW  = fqp_pkg::CntW;

  logic                   acc;
  fqp_pkg::opcode_t       op;
  fqp_pkg::cell_ctl_t     ctl;
  logic                   full;
  logic                   empty;
  logic                   found;
  logic [DEPTH:0]         hit_chain;
  logic [DataW-1:0]       cell_data [DEPTH];

  logic [CntW-1:0]        count_r;
  logic [CntW-1:0]        count_nxt;
  logic                   out_valid_r;
  logic [DataW-1:0]       out_data_r;
  logic [DataW-1:0]       data_nxt;
  fqp_pkg::status_t       out_status_r;
  fqp_pkg::status_t       status_nxt;
  logic                   out_empty_res_r;
  logic [CntW-1:0]        out_count_r;

  // Stall input only while an untaken result sits in the output register
  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;
  assign op       = fqp_pkg::opcode_t'(in_opcode);
  assign full     = count_r == CntW'(DEPTH);
  assign empty    = count_r == '0;
  assign found    = hit_chain[DEPTH];
  assign hit_chain[0] = 1'b0;

  // Drive the cell command for the accepted word
  always_comb begin
    ctl.op    = fqp_pkg::CELL_HOLD;
    ctl.value = in_value;
    ctl.count = count_r;
    if (acc) begin
      unique case (op)
        fqp_pkg::OP_ENQ: begin
          if (!full) ctl.op = fqp_pkg::CELL_ENQ;
        end
        fqp_pkg::OP_DEQ: begin
          if (!empty) ctl.op = fqp_pkg::CELL_DEQ;
        end
        fqp_pkg::OP_PEEK: ctl.op = fqp_pkg::CELL_HOLD;
        fqp_pkg::OP_PROMOTE: begin
          if (!empty) ctl.op = fqp_pkg::CELL_PRO;
        end
        default: ctl.op = fqp_pkg::CELL_HOLD;
      endcase
    end
  end

  // Decode the accepted word into status, result data and next count
  always_comb begin
    count_nxt  = count_r;
    data_nxt   = '0;
    status_nxt = fqp_pkg::ST_OK;
    unique case (op)
      fqp_pkg::OP_ENQ: begin
        if (full) begin
          status_nxt = fqp_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CntW'(1);
        end
      end
      fqp_pkg::OP_DEQ: begin
        if (empty) begin
          status_nxt = fqp_pkg::ST_EMPTY;
        end else begin
          data_nxt  = cell_data[0];
          count_nxt = count_r - CntW'(1);
        end
      end
      fqp_pkg::OP_PEEK: begin
        if (empty) status_nxt = fqp_pkg::ST_EMPTY;
        else data_nxt = cell_data[0];
      end
      fqp_pkg::OP_PROMOTE: begin
        if (empty) begin
          status_nxt = fqp_pkg::ST_EMPTY;
        end else begin
          if (!found) status_nxt = fqp_pkg::ST_NOTFOUND;
        end
      end
      default: status_nxt = fqp_pkg::ST_OK;
    endcase
  end

  // Row of slot cells, head at cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DataW-1:0] left_w;
    logic [DataW-1:0] right_w;
    if (i == 0) begin : g_head
      assign left_w = in_value;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    fqp_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .found      (found),
      .idx        (CntW'(i)),
      .left_data  (left_w),
      .right_data (right_w),
      .hit_in     (hit_chain[i]),
      .hit_out    (hit_chain[i+1]),
      .data_q     (cell_data[i])
    );
  end

  // Advance count and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result payload on accept
  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r      <= data_nxt;
      out_status_r    <= status_nxt;
      out_empty_res_r <= count_nxt == '0;
      out_count_r     <= count_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign out_status    = out_status_r;
  assign out_empty_res = out_empty_res_r;
  assign out_count     = out_count_r;

  // Checks
  `FQP_ASSERT(a_count_range, clk, rst_n, count_r <= CntW'(DEPTH))
  `FQP_ASSERT_NEXT(a_enq_count, clk, rst_n, acc && op == fqp_pkg::OP_ENQ && !full, count_r == $past(count_r) + CntW'(1))
  `FQP_ASSERT_NEXT(a_peek_head, clk, rst_n, acc && op == fqp_pkg::OP_PEEK && !empty, out_data_r == $past(cell_data[0]) && cell_data[0] == $past(cell_data[0]))
  `FQP_ASSERT(a_empty_flag, clk, rst_n, !out_valid_r || (out_empty_res_r == (out_count_r == '0)))

endmodule

`default_nettype wire

>>> tb/sv/fifo_queue_with_promote_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_promote_unit_test: self-checking bench of the promote queue
// Opens with a short directed sweep: empty-queue operations, drain of the last
// entry, promote at head, in the middle, at the tail and of a missing word,
// and fill to the full refusal. Then runs phases of random words biased
// toward fill, drain or balance. Words come from a small per-phase pool so
// that promote finds matches and duplicates. A local queue model predicts
// each untyped result word. The sender idles in bursts and the receiver
// stalls on its own pattern.
// ----------------------------------------------------------------------------

module fifo_queue_with_promote_unit_test;

  typedef struct packed {
    logic [31:0]       data;
    fqp_pkg::status_t  status;
    logic              empty;
    logic [4:0]        count;
  } queue_result_t;

  typedef struct packed {
    fqp_pkg::opcode_t  op;
    logic [31:0]       value;
    logic [4:0]        reps;
    logic              typed;
    queue_result_t     want;
  } op_row_t;

  localparam int NUM_ROWS   = 18;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_LEN  = 132;
  localparam int POOL_SIZE  = 6;

  localparam queue_result_t NO_RESULT = '{32'h0, fqp_pkg::ST_OK, 1'b0, 5'd0};

  // Directed sweep; typed results only where they are plain from the spec
  localparam op_row_t DIR_ROWS [NUM_ROWS] = '{
    '{fqp_pkg::OP_DEQ,     32'h0000_0000, 5'd1,  1'b1,
      '{32'h0, fqp_pkg::ST_EMPTY,    1'b1, 5'd0}},
    '{fqp_pkg::OP_PEEK,    32'hFFFF_FFFF, 5'd1,  1'b1,
      '{32'h0, fqp_pkg::ST_EMPTY,    1'b1, 5'd0}},
    '{fqp_pkg::OP_PROMOTE, 32'hFFFF_FFFF, 5'd1,  1'b1,
      '{32'h0, fqp_pkg::ST_EMPTY,    1'b1, 5'd0}},
    '{fqp_pkg::OP_ENQ,     32'h0000_0000, 5'd1,  1'b1,
      '{32'h0, fqp_pkg::ST_OK,       1'b0, 5'd1}},
    '{fqp_pkg::OP_DEQ,     32'hFFFF_FFFF, 5'd1,  1'b1,
      '{32'h0, fqp_pkg::ST_OK,       1'b1, 5'd0}},
    '{fqp_pkg::OP_ENQ,     32'hFFFF_FFFF, 5'd1,  1'b1,
      '{32'h0, fqp_pkg::ST_OK,       1'b0, 5'd1}},
    '{fqp_pkg::OP_ENQ,     32'hAAAA_AAAA, 5'd1,  1'b0, NO_RESULT},
    '{fqp_pkg::OP_ENQ,     32'h5555_5555, 5'd1,  1'b0, NO_RESULT},
    '{fqp_pkg::OP_ENQ,     32'h1234_5678, 5'd1,  1'b0, NO_RESULT},
    '{fqp_pkg::OP_PROMOTE, 32'h1234_5678, 5'd1,  1'b0, NO_RESULT},
    '{fqp_pkg::OP_PEEK,    32'h0000_0000, 5'd1,  1'b0, NO_RESULT},
    '{fqp_pkg::OP_PROMOTE, 32'h1234_5678, 5'd1,  1'b0, NO_RESULT},
    '{fqp_pkg::OP_PROMOTE, 32'hDEAD_BEEF, 5'd1,  1'b1,
      '{32'h0, fqp_pkg::ST_NOTFOUND, 1'b0, 5'd4}},
    '{fqp_pkg::OP_PROMOTE, 32'hAAAA_AAAA, 5'd1,  1'b0, NO_RESULT},
    '{fqp_pkg::OP_ENQ,     32'h8000_0000, 5'd12, 1'b0, NO_RESULT},
    '{fqp_pkg::OP_ENQ,     32'h7FFF_FFFF, 5'd1,  1'b1,
      '{32'h0, fqp_pkg::ST_FULL,     1'b0, 5'd16}},
    '{fqp_pkg::OP_PROMOTE, 32'h8000_000B, 5'd1,  1'b0, NO_RESULT},
    '{fqp_pkg::OP_PEEK,    32'h0000_0000, 5'd1,  1'b0, NO_RESULT}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = fqp_pkg::OP_ENQ;
  logic [31:0] in_value = 32'h0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_data;
  logic [1:0]  out_status;
  logic        out_empty_res;
  logic [4:0]  out_count;

  // Tag riding along with the driven word
  logic          row_typed = 1'b0;
  queue_result_t row_exp = NO_RESULT;

  queue_result_t pending_results [$];
  logic [31:0]   model_slots [fqp_pkg::DEPTH];
  int            model_fill = 0;
  int            errors = 0;

  // Receiver stall pattern state
  int seg_left = 0;
  int seg_mode = 0;
  int run_left = 0;

  fifo_queue_with_promote_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .out_status    (out_status),
    .out_empty_res (out_empty_res),
    .out_count     (out_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Advance the queue model by one word and return its result
  task automatic queue_model_step(input fqp_pkg::opcode_t op, input logic [31:0] val,
                                  output queue_result_t res);
    int pos;
    res = NO_RESULT;
    pos = -1;
    case (op)
      fqp_pkg::OP_ENQ: begin
        if (model_fill >= fqp_pkg::DEPTH) begin
          res.status = fqp_pkg::ST_FULL;
        end else begin
          model_slots[model_fill] = val;
          model_fill++;
        end
      end
      fqp_pkg::OP_DEQ, fqp_pkg::OP_PEEK: begin
        if (model_fill == 0) begin
          res.status = fqp_pkg::ST_EMPTY;
        end else begin
          res.data = model_slots[0];
          if (op == fqp_pkg::OP_DEQ) begin
            for (int i = 1; i < model_fill; i++) model_slots[i-1] = model_slots[i];
            model_fill--;
          end
        end
      end
      default: begin
        if (model_fill == 0) begin
          res.status = fqp_pkg::ST_EMPTY;
        end else begin
          // Match nearest the head wins
          for (int i = 0; i < model_fill && pos < 0; i++)
            if (model_slots[i] == val) pos = i;
          if (pos < 0) begin
            res.status = fqp_pkg::ST_NOTFOUND;
          end else begin
            for (int i = pos; i > 0; i--) model_slots[i] = model_slots[i-1];
            model_slots[0] = val;
          end
        end
      end
    endcase
    res.empty = (model_fill == 0);
    res.count = 5'(model_fill);
  endtask

  // Present one word and hold it until accepted
  task automatic send(input fqp_pkg::opcode_t op, input logic [31:0] val,
                      input logic typed, input queue_result_t want);
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= val;
    row_typed <= typed;
    row_exp   <= want;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Check result words, then record the prediction for each accepted word
  always @(posedge clk) begin : monitor_p
    queue_result_t got;
    queue_result_t want;
    queue_result_t pred;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_data, fqp_pkg::status_t'(out_status), out_empty_res, out_count};
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result word: data %h status %0d empty %b count %0d",
                   $time, got.data, got.status, got.empty, got.count);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch: expected data %h status %0d empty %b count %0d",
                     $time, want.data, want.status, want.empty, want.count);
            $display("%0t:           actual   data %h status %0d empty %b count %0d",
                     $time, got.data, got.status, got.empty, got.count);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        queue_model_step(fqp_pkg::opcode_t'(in_opcode), in_value, pred);
        pending_results.push_back(row_typed ? row_exp : pred);
      end
    end
  end

  // Stall the receiver in segments: none, scattered, or long runs
  always @(posedge clk) begin
    if (seg_left == 0) begin
      seg_mode <= $urandom_range(0, 2);
      seg_left <= $urandom_range(20, 80);
    end else begin
      seg_left <= seg_left - 1;
    end
    case (seg_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: begin
        if (run_left > 0) begin
          out_stall <= 1'b1;
          run_left  <= run_left - 1;
        end else if ($urandom_range(0, 9) == 0) begin
          out_stall <= 1'b1;
          run_left  <= $urandom_range(1, 12);
        end else begin
          out_stall <= 1'b0;
        end
      end
    endcase
  end

  initial begin : stimulus
    logic [31:0]      pool [POOL_SIZE];
    logic [31:0]      val;
    fqp_pkg::opcode_t op;
    int               n;
    int               burst;
    int               r;
    int               kind;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed rows
    for (int i = 0; i < NUM_ROWS; i++) begin
      for (int k = 0; k < DIR_ROWS[i].reps; k++) begin
        send(DIR_ROWS[i].op, DIR_ROWS[i].value + k, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 3));
      end
    end

    // Random phases: balanced, fill-heavy, drain-heavy
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      for (int k = 0; k < POOL_SIZE; k++) pool[k] = $urandom;
      kind = phase % 3;
      if (phase == 4) begin
        // Drain everything before going on
        pause_sender(1);
        while (pending_results.size() != 0) @(posedge clk);
      end
      n = 0;
      while (n < PHASE_LEN) begin
        burst = $urandom_range(1, 24);
        repeat (burst) begin
          if (n < PHASE_LEN) begin
            r = $urandom_range(0, 99);
            case (kind)
              0: op = (r < 25) ? fqp_pkg::OP_ENQ : (r < 50) ? fqp_pkg::OP_DEQ :
                      (r < 75) ? fqp_pkg::OP_PEEK : fqp_pkg::OP_PROMOTE;
              1: op = (r < 55) ? fqp_pkg::OP_ENQ : (r < 70) ? fqp_pkg::OP_DEQ :
                      (r < 80) ? fqp_pkg::OP_PEEK : fqp_pkg::OP_PROMOTE;
              default:
                op = (r < 20) ? fqp_pkg::OP_ENQ : (r < 70) ? fqp_pkg::OP_DEQ :
                     (r < 80) ? fqp_pkg::OP_PEEK : fqp_pkg::OP_PROMOTE;
            endcase
            val = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                             : 32'($urandom);
            send(op, val, 1'b0, NO_RESULT);
            n++;
          end
        end
        if (phase % 4 != 1) pause_sender($urandom_range(1, 6));
      end
    end

    // Let the last results drain
    pause_sender(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
